>>> rtl/core/tncb_pkg.sv
`default_nettype none

package tncb_pkg;

  // fixed-point log2 resolution
  localparam int LOG_FRAC_BITS = 16;

  // input and mantissa widths
  localparam int FREQ_W    = 22;
  localparam int P_W       = 5;               // msb position 0..21
  localparam int MANT_FRAC = 30;              // mantissa is Q1.30
  localparam int MANT_W    = MANT_FRAC + 1;

  // log2 and cents arithmetic
  localparam int LG_W          = P_W + LOG_FRAC_BITS;
  localparam int L_W           = LG_W + 1;
  localparam int CENTS_MUL_W   = 15;
  localparam int V_W           = L_W + CENTS_MUL_W;
  localparam int C_W           = V_W - LOG_FRAC_BITS;
  localparam int LOG2_REF      = (16 << LOG_FRAC_BITS) + (13109040 >> (24 - LOG_FRAC_BITS));

  localparam int CENTS_PER_OCT  = 12000;
  localparam int CENTS_PER_SEMI = 1000;
  localparam int HALF_SEMI      = 500;
  // half semitone plus enough whole octaves to keep the sum non-negative
  localparam int OFF_BIAS       = HALF_SEMI + 17 * CENTS_PER_OCT;

  // reciprocal constants, exact over the value ranges used here
  localparam int X_W           = 19;
  localparam int Q_W           = 5;
  localparam int RECIP_OCT     = 357914;      // ceil(2^32 / 12000)
  localparam int RECIP_OCT_W   = 19;
  localparam int RECIP_OCT_SH  = 32;
  localparam int OFF_W         = 14;
  localparam int NOTE_W        = 4;
  localparam int RECIP_SEMI    = 16778;       // ceil(2^24 / 1000)
  localparam int RECIP_SEMI_W  = 15;
  localparam int RECIP_SEMI_SH = 24;
  localparam int REM_W         = 10;
  localparam int TENTHS_W      = 10;
  localparam int N_W           = 9;
  localparam int BQ_W          = 6;
  localparam int RECIP_DIV_W   = 13;
  localparam int RECIP_DIV9    = 7282;        // ceil(2^16 / 9)
  localparam int RECIP_DIV13   = 5042;        // ceil(2^16 / 13)
  localparam int RECIP_DIV_SH  = 16;
  localparam int SOLO_SHIFT    = 3;           // divide by 8

  // display geometry
  localparam int COL_W         = 7;
  localparam int SOLO_LEFT     = 63;
  localparam int SOLO_RIGHT    = 64;
  localparam int DUO_SPAN      = 60;
  localparam int DUO_RIGHT_COL = 66;
  localparam int TRIO_SPAN     = 40;
  localparam int TRIO_COL1     = 44;
  localparam int TRIO_COL2     = 87;

  // pipeline depth: input, normalize, squarings, then ten arithmetic stages
  localparam int NSTG = LOG_FRAC_BITS + 12;

  // layout codes
  localparam logic [1:0] LAYOUT_SOLO = 2'd0;
  localparam logic [1:0] LAYOUT_DUO  = 2'd1;
  localparam logic [1:0] LAYOUT_TRIO = 2'd2;

  // configuration register indexes
  localparam logic CFG_LAYOUT_MODE = 1'b0;
  localparam logic CFG_DUO_LEFT    = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/tuner_note_cents_bar_top.sv
`default_nettype none

// Tuner note, cents and bar geometry. Each transfer on the in_ channel carries
// one detected frequency (1/256 Hz units) and its channel; each gives exactly
// one transfer on the out_ channel with the nearest note (0 = A .. 11 = Ab),
// the deviation in tenths of a cent (-500..499) and the bar columns for the
// current layout. No pitch or a zero frequency gives pitch_present = 0 and
// all-zero fields. The block is a 28-stage pipeline (sixteen of them are the
// squaring steps of the fixed-point log2, one 31x31 multiplier each); it takes
// one item per clock while the output is not stalled. The whole pipeline
// advances together and holds only while a finished result sits in the output
// register and out_ready is low, so in_ready depends on out_ready in the same
// cycle. Configuration is read at the last two stages and should be written
// only while the pipeline is empty.
module tuner_note_cents_bar_top
  import tncb_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,

  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [1:0]                 cfg_wdata,

  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_pitch_valid,
  input  wire logic [FREQ_W-1:0]          in_pitch_freq,
  input  wire logic [1:0]                 in_channel,

  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_pitch_present,
  output logic [NOTE_W-1:0]               out_note_index,
  output logic signed [TENTHS_W-1:0]      out_cents_tenths,
  output logic [COL_W-1:0]                out_column_offset,
  output logic [COL_W-1:0]                out_bar_left_x,
  output logic [COL_W-1:0]                out_bar_right_x
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0] layout_r;
  logic       duo_left_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layout_r   <= LAYOUT_SOLO;
      duo_left_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAYOUT_MODE: layout_r   <= cfg_wdata;
        CFG_DUO_LEFT:    duo_left_r <= cfg_wdata[0];
        default:         layout_r   <= layout_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: one shared advance, held only by a stalled output
  // ---------------------------------------------------------------------------
  logic            adv;
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] pres_r;
  logic [1:0]      chan_r [0:NSTG-2];

  assign adv      = !(vld_r[NSTG-1] && !out_ready);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // presence flag and channel ride along with the valid bits
  always_ff @(posedge clk) begin
    if (adv) begin
      pres_r    <= {pres_r[NSTG-2:0], in_pitch_valid && (in_pitch_freq != '0)};
      chan_r[0] <= in_channel;
      for (int k = 1; k < NSTG - 1; k++) begin
        chan_r[k] <= chan_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: msb position of the frequency
  // ---------------------------------------------------------------------------
  logic [P_W-1:0]    p_enc;
  logic [P_W-1:0]    s0_p_r;
  logic [FREQ_W-1:0] s0_freq_r;

  always_comb begin
    p_enc = '0;
    for (int i = 0; i < FREQ_W; i++) begin
      if (in_pitch_freq[i]) p_enc = P_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_p_r    <= p_enc;
      s0_freq_r <= in_pitch_freq;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: normalize to Q1.30; stages 2..: one squaring step each
  // entry 0 of the arrays is the normalized value, entry j after j squarings
  // ---------------------------------------------------------------------------
  logic [MANT_W-1:0]        sq_m_r   [0:LOG_FRAC_BITS];
  logic [LOG_FRAC_BITS-1:0] sq_f_r   [0:LOG_FRAC_BITS];
  logic [P_W-1:0]           sq_p_r   [0:LOG_FRAC_BITS];
  logic [MANT_W-1:0]        sq_m_nxt [1:LOG_FRAC_BITS];
  logic                     sq_bit   [1:LOG_FRAC_BITS];
  logic [MANT_W-1:0]        m_norm;

  assign m_norm = MANT_W'(s0_freq_r) << (P_W'(MANT_FRAC) - s0_p_r);

  always_comb begin
    logic [2*MANT_W-1:0] prod;
    logic [MANT_W:0]     sq;
    for (int j = 1; j <= LOG_FRAC_BITS; j++) begin
      prod = (2*MANT_W)'(sq_m_r[j-1]) * (2*MANT_W)'(sq_m_r[j-1]);
      sq   = prod[2*MANT_W-1:MANT_FRAC];
      // square at or above 2.0 sets the fraction bit and halves
      sq_bit[j]   = sq[MANT_W];
      sq_m_nxt[j] = sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_m_r[0] <= m_norm;
      sq_f_r[0] <= '0;
      sq_p_r[0] <= s0_p_r;
      for (int j = 1; j <= LOG_FRAC_BITS; j++) begin
        sq_m_r[j] <= sq_m_nxt[j];
        sq_f_r[j] <= {sq_f_r[j-1][LOG_FRAC_BITS-2:0], sq_bit[j]};
        sq_p_r[j] <= sq_p_r[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // log2 relative to A440, scaled to tenths of a cent (floor)
  // ---------------------------------------------------------------------------
  logic signed [L_W-1:0] l_nxt, l_r;
  logic signed [V_W-1:0] v_nxt, v_r;
  logic signed [C_W-1:0] x_full;
  logic [X_W-1:0]        x_r;

  assign l_nxt  = L_W'({1'b0, sq_p_r[LOG_FRAC_BITS], sq_f_r[LOG_FRAC_BITS]})
                - L_W'(LOG2_REF);
  assign v_nxt  = V_W'(l_r) * V_W'(CENTS_PER_OCT);
  // arithmetic shift gives floor; bias keeps the sum non-negative
  assign x_full = $signed(v_r[V_W-1:LOG_FRAC_BITS]) + C_W'(OFF_BIAS);

  always_ff @(posedge clk) begin
    if (adv) begin
      l_r <= l_nxt;
      v_r <= v_nxt;
      x_r <= x_full[X_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // modulo one octave by reciprocal multiply
  // ---------------------------------------------------------------------------
  logic [X_W+RECIP_OCT_W-1:0] oct_prod;
  logic [Q_W-1:0]             oq_r;
  logic [X_W-1:0]             x2_r;
  logic [X_W-1:0]             off_full;
  logic [OFF_W-1:0]           off_r;

  assign oct_prod = (X_W+RECIP_OCT_W)'(x_r) * (X_W+RECIP_OCT_W)'(RECIP_OCT);
  assign off_full = x2_r - X_W'(oq_r) * X_W'(CENTS_PER_OCT);

  always_ff @(posedge clk) begin
    if (adv) begin
      oq_r  <= oct_prod[RECIP_OCT_SH +: Q_W];
      x2_r  <= x_r;
      off_r <= off_full[OFF_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // note index and remainder within the semitone
  // ---------------------------------------------------------------------------
  logic [OFF_W+RECIP_SEMI_W-1:0] semi_prod;
  logic [NOTE_W-1:0]             note_r, note2_r;
  logic [OFF_W-1:0]              off2_r;
  logic [OFF_W-1:0]              rem_full;
  logic [REM_W-1:0]              rem_r;

  assign semi_prod = (OFF_W+RECIP_SEMI_W)'(off_r) * (OFF_W+RECIP_SEMI_W)'(RECIP_SEMI);
  assign rem_full  = off2_r - OFF_W'(note_r) * OFF_W'(CENTS_PER_SEMI);

  always_ff @(posedge clk) begin
    if (adv) begin
      note_r  <= semi_prod[RECIP_SEMI_SH +: NOTE_W];
      off2_r  <= off_r;
      note2_r <= note_r;
      rem_r   <= rem_full[REM_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // cents output, bar distance and side
  // ---------------------------------------------------------------------------
  logic [REM_W-1:0]    d_val;
  logic                sharp_nxt;
  logic [REM_W-1:0]    n_full;
  logic [TENTHS_W-1:0] tenths_r, tenths2_r;
  logic                sharp_r, sharp2_r;
  logic [N_W-1:0]      n_r;
  logic [NOTE_W-1:0]   note3_r, note4_r;

  always_comb begin
    if (rem_r < REM_W'(HALF_SEMI)) d_val = rem_r + REM_W'(HALF_SEMI);
    else                           d_val = rem_r - REM_W'(HALF_SEMI);
    sharp_nxt = d_val > REM_W'(HALF_SEMI);
    n_full    = sharp_nxt ? (REM_W'(CENTS_PER_SEMI) - d_val) : d_val;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tenths_r <= TENTHS_W'(rem_r) - TENTHS_W'(HALF_SEMI);
      sharp_r  <= sharp_nxt;
      n_r      <= n_full[N_W-1:0];
      note3_r  <= note2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // bar length: divide by 8, 9 or 13 depending on layout
  // ---------------------------------------------------------------------------
  logic [N_W+RECIP_DIV_W-1:0] div_prod;
  logic [BQ_W-1:0]            bq_nxt, bq_r;

  always_comb begin
    div_prod = '0;
    unique case (layout_r)
      LAYOUT_DUO: begin
        div_prod = (N_W+RECIP_DIV_W)'(n_r) * (N_W+RECIP_DIV_W)'(RECIP_DIV9);
        bq_nxt   = div_prod[RECIP_DIV_SH +: BQ_W];
      end
      LAYOUT_TRIO: begin
        div_prod = (N_W+RECIP_DIV_W)'(n_r) * (N_W+RECIP_DIV_W)'(RECIP_DIV13);
        bq_nxt   = div_prod[RECIP_DIV_SH +: BQ_W];
      end
      default: begin
        bq_nxt = BQ_W'(n_r >> SOLO_SHIFT);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bq_r      <= bq_nxt;
      sharp2_r  <= sharp_r;
      tenths2_r <= tenths_r;
      note4_r   <= note3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // output stage: columns per layout, zeros when no pitch
  // ---------------------------------------------------------------------------
  logic [1:0]       chan_q;
  logic [COL_W-1:0] col_a, col_l, col_r;
  logic [COL_W-1:0] bq_col;

  assign chan_q = chan_r[NSTG-2];
  assign bq_col = COL_W'(bq_r);

  always_comb begin
    col_a = '0;
    col_l = '0;
    col_r = '0;
    unique case (layout_r)
      LAYOUT_DUO: begin
        // channel three never matches, so it lands in the right half
        col_a = (chan_q == {1'b0, duo_left_r}) ? '0 : COL_W'(DUO_RIGHT_COL);
        if (sharp2_r) begin
          col_l = col_a + COL_W'(DUO_SPAN) - bq_col;
          col_r = col_a + COL_W'(DUO_SPAN);
        end else begin
          col_l = col_a;
          col_r = col_a + bq_col;
        end
      end
      LAYOUT_TRIO: begin
        if (chan_q == 2'd1)      col_a = COL_W'(TRIO_COL1);
        else if (chan_q == 2'd2) col_a = COL_W'(TRIO_COL2);
        else                     col_a = '0;
        if (sharp2_r) begin
          col_l = col_a + COL_W'(TRIO_SPAN) - bq_col;
          col_r = col_a + COL_W'(TRIO_SPAN);
        end else begin
          col_l = col_a;
          col_r = col_a + bq_col;
        end
      end
      default: begin
        // solo and the unused code: bar grows out of the two center columns
        col_a = '0;
        if (sharp2_r) begin
          col_l = COL_W'(SOLO_LEFT) - bq_col;
          col_r = COL_W'(SOLO_RIGHT);
        end else begin
          col_l = COL_W'(SOLO_LEFT);
          col_r = COL_W'(SOLO_RIGHT) + bq_col;
        end
      end
    endcase
  end

  logic [NOTE_W-1:0]   o_note_r;
  logic [TENTHS_W-1:0] o_tenths_r;
  logic [COL_W-1:0]    o_col_r, o_left_r, o_right_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pres_r[NSTG-2]) begin
        o_note_r   <= note4_r;
        o_tenths_r <= tenths2_r;
        o_col_r    <= col_a;
        o_left_r   <= col_l;
        o_right_r  <= col_r;
      end else begin
        o_note_r   <= '0;
        o_tenths_r <= '0;
        o_col_r    <= '0;
        o_left_r   <= '0;
        o_right_r  <= '0;
      end
    end
  end

  assign out_valid         = vld_r[NSTG-1];
  assign out_pitch_present = pres_r[NSTG-1];
  assign out_note_index    = o_note_r;
  assign out_cents_tenths  = $signed(o_tenths_r);
  assign out_column_offset = o_col_r;
  assign out_bar_left_x    = o_left_r;
  assign out_bar_right_x   = o_right_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // a held pipeline keeps its occupancy and its bar columns
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(vld_r) && $stable(out_bar_left_x) && $stable(out_bar_right_x))
    else $error("pipeline moved while stalled");

  // no pitch comes out as all-zero fields
  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pitch_present |->
      out_note_index == '0 && out_cents_tenths == '0 && out_column_offset == '0 &&
      out_bar_left_x == '0 && out_bar_right_x == '0)
    else $error("absent pitch with nonzero fields");

  // note and cents stay inside one octave and half a semitone
  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pitch_present |->
      out_note_index <= NOTE_W'(11) &&
      out_cents_tenths >= -TENTHS_W'(HALF_SEMI) &&
      out_cents_tenths < TENTHS_W'(HALF_SEMI))
    else $error("note or cents out of range");

  // the bar starts at or after its channel offset and runs left to right
  a_bar_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pitch_present |->
      out_bar_left_x <= out_bar_right_x && out_bar_left_x >= out_column_offset)
    else $error("bar columns out of order");
`endif

endmodule

`default_nettype wire
